[hdl/racr_pkg.sv]
package racr_pkg;

  // Default configuration of the counter store.
  localparam int DEF_CHANNEL_BITS    = 1;
  localparam int DEF_RANK_BITS       = 1;
  localparam int DEF_BANK_GROUP_BITS = 2;
  localparam int DEF_BANK_BITS       = 2;
  localparam int DEF_ROW_BITS        = 10;
  localparam int DEF_COUNT_BITS      = 16;

  // Fixed field widths of the request and result items.
  localparam int CH_W       = 1;
  localparam int RK_W       = 1;
  localparam int BG_W       = 2;
  localparam int BK_W       = 2;
  localparam int ROW_W      = 10;
  localparam int COL_W      = 10;
  localparam int TIME_W     = 48;
  localparam int THR_W      = 16;
  localparam int ROWCNT_W   = 11;
  localparam int CFG_DATA_W = 16;

  // Register reset values.
  localparam logic [THR_W-1:0]    THRESHOLD_RST = 16'd4096;
  localparam logic [ROWCNT_W-1:0] ROW_COUNT_RST = 11'd1024;

  // Result kinds.
  localparam logic KIND_ACCESS = 1'b0;
  localparam logic NEI_ACT     = 1'b1;

  // Job queue between the front and the back.
  localparam int Q_DEPTH = 4;
  localparam int Q_AW    = $clog2(Q_DEPTH);
  localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

  // Configuration register indexes.
  typedef enum logic [0:0] {
    CFG_THRESHOLD = 1'b0,
    CFG_ROW_COUNT = 1'b1
  } cfg_reg_t;

  // Which result of a job the back emits next.
  typedef enum logic [1:0] {
    PH_ACCESS,
    PH_LOW,
    PH_HIGH
  } phase_t;

  typedef struct packed {
    logic [CH_W-1:0]   channel;
    logic [RK_W-1:0]   rank;
    logic [BG_W-1:0]   bank_group;
    logic [BK_W-1:0]   bank;
    logic [ROW_W-1:0]  row;
    logic [COL_W-1:0]  column;
    logic              is_write;
    logic [TIME_W-1:0] time_req;
  } req_t;

  typedef struct packed {
    logic              kind;
    logic [CH_W-1:0]   out_channel;
    logic [RK_W-1:0]   out_rank;
    logic [BG_W-1:0]   out_bank_group;
    logic [BK_W-1:0]   out_bank;
    logic [ROW_W-1:0]  out_row;
    logic [COL_W-1:0]  out_column;
    logic              out_is_write;
    logic [TIME_W-1:0] out_time;
    logic              last;
  } rsp_t;

  // A classified request: the access plus which neighbours to activate.
  typedef struct packed {
    req_t req;
    logic low_nb;
    logic high_nb;
  } job_t;

  typedef struct packed {
    logic               empty;
    logic [Q_CNT_W-1:0] count;
  } q_stat_t;

endpackage

[hdl/racr_front.sv]
module racr_front #(
  parameter int CHANNEL_BITS    = racr_pkg::DEF_CHANNEL_BITS,
  parameter int RANK_BITS       = racr_pkg::DEF_RANK_BITS,
  parameter int BANK_GROUP_BITS = racr_pkg::DEF_BANK_GROUP_BITS,
  parameter int BANK_BITS       = racr_pkg::DEF_BANK_BITS,
  parameter int ROW_BITS        = racr_pkg::DEF_ROW_BITS,
  parameter int COUNT_BITS      = racr_pkg::DEF_COUNT_BITS
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_push,
  output logic                              in_full,
  input  racr_pkg::req_t                    in_req,
  input  logic                              cfg_we,
  input  racr_pkg::cfg_reg_t                cfg_index,
  input  logic [racr_pkg::CFG_DATA_W-1:0]   cfg_wdata,
  input  racr_pkg::q_stat_t                 q_stat,
  output logic                              q_push,
  output racr_pkg::job_t                    q_job
);

  localparam int ADDR_W      = CHANNEL_BITS + RANK_BITS + BANK_GROUP_BITS + BANK_BITS + ROW_BITS;
  localparam int STORE_DEPTH = 1 << ADDR_W;
  localparam int CMP_W       = (COUNT_BITS > racr_pkg::THR_W) ? COUNT_BITS : racr_pkg::THR_W;
  localparam int SH_BG       = ROW_BITS + BANK_BITS;
  localparam int SH_RK       = SH_BG + BANK_GROUP_BITS;
  localparam int SH_CH       = SH_RK + RANK_BITS;
  localparam logic [31:0] CH_MASK  = (32'd1 << CHANNEL_BITS) - 32'd1;
  localparam logic [31:0] RK_MASK  = (32'd1 << RANK_BITS) - 32'd1;
  localparam logic [31:0] BG_MASK  = (32'd1 << BANK_GROUP_BITS) - 32'd1;
  localparam logic [31:0] BK_MASK  = (32'd1 << BANK_BITS) - 32'd1;
  localparam logic [31:0] ROW_MASK = (32'd1 << ROW_BITS) - 32'd1;
  localparam logic [racr_pkg::ROWCNT_W-1:0] ROW_TOP =
    racr_pkg::ROWCNT_W'((1 << racr_pkg::ROW_W) - 1);

  logic [racr_pkg::THR_W-1:0]    thr_r;
  logic [racr_pkg::ROWCNT_W-1:0] row_count_r;

  logic                  clr_active_r;
  logic [ADDR_W-1:0]     clr_addr_r;

  logic [COUNT_BITS-1:0] cnt_mem [STORE_DEPTH];
  logic [COUNT_BITS-1:0] rd_cnt_r;

  logic                  accept;
  logic [31:0]           s0_addr_w;
  logic [ADDR_W-1:0]     s0_addr;
  racr_pkg::req_t        s0_req;

  logic                  s1_valid_r;
  racr_pkg::req_t        s1_req_r;
  logic [ADDR_W-1:0]     s1_addr_r;

  logic                  fwd_valid_r;
  logic [ADDR_W-1:0]     fwd_addr_r;
  logic [COUNT_BITS-1:0] fwd_cnt_r;

  logic [COUNT_BITS-1:0] old_cnt;
  logic [COUNT_BITS-1:0] base_cnt;
  logic [COUNT_BITS-1:0] new_cnt;
  logic                  hit;
  logic [racr_pkg::ROWCNT_W-1:0] row_up;

  logic                  mem_we;
  logic [ADDR_W-1:0]     mem_waddr;
  logic [COUNT_BITS-1:0] mem_wdata;

  logic [racr_pkg::Q_CNT_W:0] occupied;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r       <= racr_pkg::THRESHOLD_RST;
      row_count_r <= racr_pkg::ROW_COUNT_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        racr_pkg::CFG_THRESHOLD: thr_r       <= cfg_wdata;
        racr_pkg::CFG_ROW_COUNT: row_count_r <= cfg_wdata[racr_pkg::ROWCNT_W-1:0];
      endcase
    end
  end

  // Requests are refused while the store is cleared and when the queue has no room
  // for both the request in flight and a new one.
  assign occupied = {1'b0, q_stat.count} + (racr_pkg::Q_CNT_W + 1)'(s1_valid_r);
  assign in_full  = clr_active_r || (occupied >= (racr_pkg::Q_CNT_W + 1)'(racr_pkg::Q_DEPTH));
  assign accept   = in_push && !in_full;

  // Counter address from the decoded row coordinates.
  assign s0_addr_w = ((32'(in_req.channel)    & CH_MASK) << SH_CH) |
                     ((32'(in_req.rank)       & RK_MASK) << SH_RK) |
                     ((32'(in_req.bank_group) & BG_MASK) << SH_BG) |
                     ((32'(in_req.bank)       & BK_MASK) << ROW_BITS) |
                     (32'(in_req.row) & ROW_MASK);
  assign s0_addr = s0_addr_w[ADDR_W-1:0];

  always_comb begin
    s0_req     = in_req;
    s0_req.row = in_req.row & racr_pkg::ROW_W'(ROW_MASK);
  end

  // Counter store: one write port and one registered read port.
  always_ff @(posedge clk) begin
    if (mem_we) begin
      cnt_mem[mem_waddr] <= mem_wdata;
    end
    rd_cnt_r <= cnt_mem[s0_addr];
  end

  // Clearing pass over the whole store after reset.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_active_r <= 1'b1;
      clr_addr_r   <= '0;
    end else if (clr_active_r) begin
      clr_addr_r <= clr_addr_r + 1'b1;
      if (clr_addr_r == '1) begin
        clr_active_r <= 1'b0;
      end
    end
  end

  // Read stage: the request waits here for its counter.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      fwd_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= accept;
      fwd_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_req_r  <= s0_req;
      s1_addr_r <= s0_addr;
    end
    fwd_addr_r <= s1_addr_r;
    fwd_cnt_r  <= new_cnt;
  end

  // The previous request's write lands on the same edge as this read, so it is forwarded.
  assign old_cnt  = (fwd_valid_r && (fwd_addr_r == s1_addr_r)) ? fwd_cnt_r : rd_cnt_r;
  assign base_cnt = (CMP_W'(old_cnt) == CMP_W'(thr_r)) ? '0 : old_cnt;
  assign new_cnt  = base_cnt + COUNT_BITS'(1);
  assign hit      = (CMP_W'(new_cnt) == CMP_W'(thr_r));
  assign row_up   = {1'b0, s1_req_r.row} + racr_pkg::ROWCNT_W'(1);

  // Classify the request and hand it to the queue.
  assign q_push       = s1_valid_r;
  assign q_job.req    = s1_req_r;
  assign q_job.low_nb  = hit && (s1_req_r.row != '0);
  assign q_job.high_nb = hit && (row_up < row_count_r) && (row_up <= ROW_TOP);

  // Write port is shared by the clearing pass and the counter update.
  assign mem_we    = clr_active_r || s1_valid_r;
  assign mem_waddr = clr_active_r ? clr_addr_r : s1_addr_r;
  assign mem_wdata = clr_active_r ? '0 : new_cnt;

  // The reserved slot guarantees the queue always has room for the request in flight.
  a_queue_room: assert property (@(posedge clk) disable iff (!rst_n)
    s1_valid_r |-> (q_stat.count < racr_pkg::Q_CNT_W'(racr_pkg::Q_DEPTH)))
    else $error("queue has no room for the request in flight");

  // No request enters while the store is being cleared.
  a_clear_idle: assert property (@(posedge clk) disable iff (!rst_n)
    clr_active_r |=> !s1_valid_r)
    else $error("request accepted during the clearing pass");

endmodule

[hdl/racr_queue.sv]
module racr_queue (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  racr_pkg::job_t    push_job,
  input  logic              pop,
  output racr_pkg::job_t    head,
  output racr_pkg::q_stat_t stat
);

  racr_pkg::job_t                   entries_r [racr_pkg::Q_DEPTH];
  logic [racr_pkg::Q_AW-1:0]        wr_ptr_r;
  logic [racr_pkg::Q_AW-1:0]        rd_ptr_r;
  logic [racr_pkg::Q_CNT_W-1:0]     count_r;

  // Pointers and fill level.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      if (push && !pop) begin
        count_r <= count_r + 1'b1;
      end else if (pop && !push) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

  // Job storage.
  always_ff @(posedge clk) begin
    if (push) begin
      entries_r[wr_ptr_r] <= push_job;
    end
  end

  assign head       = entries_r[rd_ptr_r];
  assign stat.empty = (count_r == '0);
  assign stat.count = count_r;

  a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> (count_r != '0))
    else $error("job queue popped while empty");

  a_push_room: assert property (@(posedge clk) disable iff (!rst_n)
    (push && !pop) |-> (count_r < racr_pkg::Q_CNT_W'(racr_pkg::Q_DEPTH)))
    else $error("job queue pushed while full");

endmodule

[hdl/racr_back.sv]
module racr_back (
  input  logic              clk,
  input  logic              rst_n,
  input  racr_pkg::q_stat_t q_stat,
  input  racr_pkg::job_t    q_head,
  output logic              q_pop,
  output logic              out_empty,
  input  logic              out_pop,
  output racr_pkg::rsp_t    out_rsp
);

  racr_pkg::phase_t phase_r;
  racr_pkg::phase_t phase_nxt;
  racr_pkg::rsp_t   rsp;
  racr_pkg::rsp_t   out_rsp_r;
  logic             out_valid_r;
  logic             slot_free;
  logic             emit;

  // Emit when a job is queued and the output register is free or being drained.
  assign slot_free = !out_valid_r || out_pop;
  assign emit      = slot_free && !q_stat.empty;

  // Next phase within the current job.
  always_comb begin
    phase_nxt = phase_r;
    if (emit) begin
      unique case (phase_r)
        racr_pkg::PH_ACCESS: begin
          if (q_head.low_nb) begin
            phase_nxt = racr_pkg::PH_LOW;
          end else if (q_head.high_nb) begin
            phase_nxt = racr_pkg::PH_HIGH;
          end else begin
            phase_nxt = racr_pkg::PH_ACCESS;
          end
        end
        racr_pkg::PH_LOW: begin
          phase_nxt = q_head.high_nb ? racr_pkg::PH_HIGH : racr_pkg::PH_ACCESS;
        end
        racr_pkg::PH_HIGH: phase_nxt = racr_pkg::PH_ACCESS;
        default:           phase_nxt = racr_pkg::PH_ACCESS;
      endcase
    end
  end

  // Result for the current phase of the job at the queue head.
  always_comb begin
    rsp.out_channel    = q_head.req.channel;
    rsp.out_rank       = q_head.req.rank;
    rsp.out_bank_group = q_head.req.bank_group;
    rsp.out_bank       = q_head.req.bank;
    rsp.out_column     = q_head.req.column;
    rsp.kind           = racr_pkg::KIND_ACCESS;
    rsp.out_row        = q_head.req.row;
    rsp.out_is_write   = q_head.req.is_write;
    rsp.out_time       = q_head.req.time_req;
    rsp.last           = !q_head.low_nb && !q_head.high_nb;
    unique case (phase_r)
      racr_pkg::PH_ACCESS: begin
      end
      racr_pkg::PH_LOW: begin
        rsp.kind         = racr_pkg::NEI_ACT;
        rsp.out_row      = q_head.req.row - racr_pkg::ROW_W'(1);
        rsp.out_is_write = 1'b0;
        rsp.out_time     = q_head.req.time_req + racr_pkg::TIME_W'(1);
        rsp.last         = !q_head.high_nb;
      end
      racr_pkg::PH_HIGH: begin
        rsp.kind         = racr_pkg::NEI_ACT;
        rsp.out_row      = q_head.req.row + racr_pkg::ROW_W'(1);
        rsp.out_is_write = 1'b0;
        rsp.out_time     = q_head.req.time_req +
                           (q_head.low_nb ? racr_pkg::TIME_W'(2) : racr_pkg::TIME_W'(1));
        rsp.last         = 1'b1;
      end
      default: begin
      end
    endcase
  end

  assign q_pop = emit && rsp.last;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= racr_pkg::PH_ACCESS;
      out_valid_r <= 1'b0;
    end else begin
      phase_r <= phase_nxt;
      if (emit) begin
        out_valid_r <= 1'b1;
      end else if (out_pop) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (emit) begin
      out_rsp_r <= rsp;
    end
  end

  assign out_empty = !out_valid_r;
  assign out_rsp   = out_rsp_r;

  a_low_phase: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == racr_pkg::PH_LOW) |-> (!q_stat.empty && q_head.low_nb))
    else $error("lower neighbour phase without a lower neighbour");

  a_high_phase: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == racr_pkg::PH_HIGH) |-> (!q_stat.empty && q_head.high_nb))
    else $error("upper neighbour phase without an upper neighbour");

endmodule

[hdl/row_activation_counter_refresh.sv]
// Counter-based rowhammer mitigation. Every row access request pushed in comes out
// again, and when its row's activation counter reaches the threshold it is followed
// by neighbor activations for row-1 and row+1 where those rows exist. After reset
// the counter store is cleared one entry per cycle: in_full stays high until all
// 2^(CHANNEL_BITS + RANK_BITS + BANK_GROUP_BITS + BANK_BITS + ROW_BITS) entries
// (65536 with the defaults) are cleared, while configuration writes are taken as
// usual. Afterwards a request is accepted every cycle while the job queue has room;
// the counter update is a read-modify-write on the two-port store with forwarding
// between neighboring requests. The result port delivers one result per cycle while
// out_pop drains it, so a request yields one result when it triggers nothing and two
// or three results when it brings neighbor activations.
module row_activation_counter_refresh #(
  parameter int CHANNEL_BITS    = racr_pkg::DEF_CHANNEL_BITS,
  parameter int RANK_BITS       = racr_pkg::DEF_RANK_BITS,
  parameter int BANK_GROUP_BITS = racr_pkg::DEF_BANK_GROUP_BITS,
  parameter int BANK_BITS       = racr_pkg::DEF_BANK_BITS,
  parameter int ROW_BITS        = racr_pkg::DEF_ROW_BITS,
  parameter int COUNT_BITS      = racr_pkg::DEF_COUNT_BITS
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_push,
  output logic                            in_full,
  input  racr_pkg::req_t                  in_req,
  output logic                            out_empty,
  input  logic                            out_pop,
  output racr_pkg::rsp_t                  out_rsp,
  input  logic                            cfg_we,
  input  racr_pkg::cfg_reg_t              cfg_index,
  input  logic [racr_pkg::CFG_DATA_W-1:0] cfg_wdata
);

  logic              q_push;
  logic              q_pop;
  racr_pkg::job_t    q_job;
  racr_pkg::job_t    q_head;
  racr_pkg::q_stat_t q_stat;

  racr_front #(
    .CHANNEL_BITS    (CHANNEL_BITS),
    .RANK_BITS       (RANK_BITS),
    .BANK_GROUP_BITS (BANK_GROUP_BITS),
    .BANK_BITS       (BANK_BITS),
    .ROW_BITS        (ROW_BITS),
    .COUNT_BITS      (COUNT_BITS)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_push   (in_push),
    .in_full   (in_full),
    .in_req    (in_req),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .q_stat    (q_stat),
    .q_push    (q_push),
    .q_job     (q_job)
  );

  racr_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_job (q_job),
    .pop      (q_pop),
    .head     (q_head),
    .stat     (q_stat)
  );

  racr_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_stat    (q_stat),
    .q_head    (q_head),
    .q_pop     (q_pop),
    .out_empty (out_empty),
    .out_pop   (out_pop),
    .out_rsp   (out_rsp)
  );

endmodule
